>>> hdl/braced_hex_id_parser_top_defines.svh
// ----------------------------------------------------------------------------
// Braced hex id parser assertion macros
// Shared property shorthands for the concurrent checks of the parser.
// ----------------------------------------------------------------------------
`ifndef BRACED_HEX_ID_PARSER_TOP_DEFINES_SVH
`define BRACED_HEX_ID_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BHID_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("bhid same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BHID_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("bhid next-cycle check failed");

`endif

>>> hdl/bhid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Braced hex id parser package
// Word types, character and position constants and the hex digit decoder.
// ----------------------------------------------------------------------------
package bhid_pkg;

    // Characters of the braced format.
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_DIG_0  = 8'h30;
    localparam logic [7:0] CHAR_DIG_9  = 8'h39;
    localparam logic [7:0] CHAR_LC_A   = 8'h61;
    localparam logic [7:0] CHAR_LC_F   = 8'h66;
    localparam logic [7:0] CHAR_UC_A   = 8'h41;
    localparam logic [7:0] CHAR_UC_F   = 8'h46;

    // Character positions within the identifier.
    localparam int          POS_W       = 5;
    localparam logic [4:0]  POS_LBRACE  = 5'd0;
    localparam logic [4:0]  POS_LAST_HI = 5'd8;
    localparam logic [4:0]  POS_DASH    = 5'd9;
    localparam logic [4:0]  POS_RBRACE  = 5'd18;
    localparam logic [4:0]  FULL_LENGTH = 5'd19;

    // Letters a..f and A..F have low nibble 1..6, which maps to 10..15.
    localparam logic [3:0]  LETTER_OFS  = 4'd9;

    typedef struct packed {
        logic [7:0] char_byte;
    } char_word_t;

    typedef struct packed {
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic        ok;
    } id_word_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one ASCII character as a hex digit.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b0;
        d.value = c[3:0];
        if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9)
        begin
            d.valid = 1'b1;
        end
        else if ((c >= CHAR_LC_A && c <= CHAR_LC_F) ||
                 (c >= CHAR_UC_A && c <= CHAR_UC_F))
        begin
            d.valid = 1'b1;
            d.value = c[3:0] + LETTER_OFS;
        end
        return d;
    endfunction

endpackage

>>> hdl/bhid_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Braced hex id stream interface
// Valid/ready channel that carries one word of the given payload type.
// ----------------------------------------------------------------------------
interface bhid_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/bhid_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Braced hex id input register
// Holds one accepted character word until the parse core takes it.
// ----------------------------------------------------------------------------
module bhid_in_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bhid_pkg::char_word_t in_word,
    output logic                 held_valid,
    output bhid_pkg::char_word_t held_word,
    input  logic                 take
);

    logic                 valid_reg;
    logic                 valid_next;
    bhid_pkg::char_word_t word_reg;

    // The slot is free when empty or when its word leaves this cycle.
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register loads on every accepted word.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

>>> hdl/bhid_parse_core.sv
`timescale 1ns / 1ps
`include "braced_hex_id_parser_top_defines.svh"
// ----------------------------------------------------------------------------
// Braced hex id parse core
// Position counter, two hex accumulators and the sticky failure flag; on the
// terminating zero byte it forms the result word and returns to start.
// ----------------------------------------------------------------------------
module bhid_parse_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 held_valid,
    input  bhid_pkg::char_word_t held_word,
    input  logic                 out_free,
    output logic                 take,
    output logic                 res_valid,
    output bhid_pkg::id_word_t   res_word
);

    logic [bhid_pkg::POS_W-1:0] position_reg;
    logic [bhid_pkg::POS_W-1:0] position_next;
    logic [31:0]                first_acc_reg;
    logic [31:0]                first_acc_next;
    logic [31:0]                second_acc_reg;
    logic [31:0]                second_acc_next;
    logic                       failed_reg;
    logic                       failed_next;

    logic                       is_term;
    logic                       good;
    bhid_pkg::hex_digit_t       digit;

    // A character without a result always moves on; the terminator needs room.
    assign is_term   = (held_word.char_byte == bhid_pkg::CHAR_NUL);
    assign take      = held_valid && (!is_term || out_free);
    assign res_valid = take && is_term;
    assign digit     = bhid_pkg::hex_decode(held_word.char_byte);

    // Result word for the terminator.
    assign good                 = !failed_reg && (position_reg == bhid_pkg::FULL_LENGTH);
    assign res_word.first_word  = good ? first_acc_reg : 32'd0;
    assign res_word.second_word = good ? second_acc_reg : 32'd0;
    assign res_word.ok          = good;

    // Per-character state update.
    always_comb
    begin
        position_next   = position_reg;
        first_acc_next  = first_acc_reg;
        second_acc_next = second_acc_reg;
        failed_next     = failed_reg;
        if (take)
        begin
            priority if (is_term)
            begin
                position_next   = '0;
                first_acc_next  = 32'd0;
                second_acc_next = 32'd0;
                failed_next     = 1'b0;
            end
            else if (position_reg >= bhid_pkg::FULL_LENGTH)
            begin
                failed_next   = 1'b1;
                position_next = bhid_pkg::FULL_LENGTH;
            end
            else
            begin
                position_next = position_reg + 5'd1;
                priority if (position_reg == bhid_pkg::POS_LBRACE)
                begin
                    if (held_word.char_byte != bhid_pkg::CHAR_LBRACE)
                    begin
                        failed_next = 1'b1;
                    end
                end
                else if (position_reg == bhid_pkg::POS_DASH)
                begin
                    if (held_word.char_byte != bhid_pkg::CHAR_DASH)
                    begin
                        failed_next = 1'b1;
                    end
                end
                else if (position_reg == bhid_pkg::POS_RBRACE)
                begin
                    if (held_word.char_byte != bhid_pkg::CHAR_RBRACE)
                    begin
                        failed_next = 1'b1;
                    end
                end
                else if (!digit.valid)
                begin
                    failed_next = 1'b1;
                end
                else if (position_reg <= bhid_pkg::POS_LAST_HI)
                begin
                    first_acc_next = {first_acc_reg[27:0], digit.value};
                end
                else
                begin
                    second_acc_next = {second_acc_reg[27:0], digit.value};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            first_acc_reg  <= 32'd0;
            second_acc_reg <= 32'd0;
            failed_reg     <= 1'b0;
        end
        else
        begin
            position_reg   <= position_next;
            first_acc_reg  <= first_acc_next;
            second_acc_reg <= second_acc_next;
            failed_reg     <= failed_next;
        end
    end

    // The position counter saturates at the full identifier length.
    `BHID_ASSERT_SAME(a_pos_range, clk, rst_n, 1'b1, position_reg <= bhid_pkg::FULL_LENGTH)
    // A terminator returns the parser to its start state.
    `BHID_ASSERT_NEXT(a_term_restart, clk, rst_n, res_valid, position_reg == '0 && !failed_reg)
    // A character past the closing brace marks the string as bad.
    `BHID_ASSERT_NEXT(a_late_char_fails, clk, rst_n,
        take && !is_term && position_reg == bhid_pkg::FULL_LENGTH, failed_reg)
    // The failure flag holds until the terminator is taken.
    `BHID_ASSERT_NEXT(a_failed_sticky, clk, rst_n, failed_reg && !res_valid, failed_reg)

endmodule

>>> hdl/bhid_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Braced hex id output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module bhid_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    input  bhid_pkg::id_word_t res_word,
    output logic               out_free,
    output logic               out_valid,
    input  logic               out_ready,
    output bhid_pkg::id_word_t out_word
);

    logic               valid_reg;
    logic               valid_next;
    bhid_pkg::id_word_t word_reg;

    // Room for a new word when empty or when the held word leaves now.
    assign out_free   = !valid_reg || out_ready;
    assign valid_next = res_valid || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register loads on every new result.
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            word_reg <= res_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> hdl/braced_hex_id_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Braced hex id parser top level
// Checks a "{xxxxxxxx-xxxxxxxx}" identifier one character per word and
// returns both 32-bit hex values with an ok flag on the zero terminator.
// ----------------------------------------------------------------------------
// The block takes one character word per clock cycle, save a terminator held
// back for room in the result register: each character is registered, then
// parsed by the position counter and accumulator update, which sets the rate
// of one character per cycle. Only the zero byte produces a result word, which
// goes into the result register that drives id_out. A result waiting on id_out
// does not stop the block from taking further characters; only a second
// terminator waits until the first result has been taken. A malformed string,
// including an empty, short or overlong one, gives zero words with ok low.
module braced_hex_id_parser_top (
    input  logic           clk,
    input  logic           rst_n,
    bhid_stream_if.sink    char_in,
    bhid_stream_if.source  id_out
);

    logic                 held_valid;
    bhid_pkg::char_word_t held_word;
    logic                 take;
    logic                 out_free;
    logic                 res_valid;
    bhid_pkg::id_word_t   res_word;

    // Input register.
    bhid_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (char_in.valid),
        .in_ready   (char_in.ready),
        .in_word    (char_in.payload),
        .held_valid (held_valid),
        .held_word  (held_word),
        .take       (take)
    );

    // Parser state and result logic.
    bhid_parse_core u_parse_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_word  (held_word),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res_word   (res_word)
    );

    // Result register.
    bhid_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_word  (res_word),
        .out_free  (out_free),
        .out_valid (id_out.valid),
        .out_ready (id_out.ready),
        .out_word  (id_out.payload)
    );

endmodule

>>> dv/tb_braced_hex_id_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Braced hex id parser testbench
// Feeds identifier strings one character word at a time into the parser,
// mixing known corner strings with random well-formed, damaged and noise
// strings. A parser model in the testbench predicts each result word, and
// the monitor compares it field by field with what the block returns. Both
// sides of the stream idle in random bursts.
// ----------------------------------------------------------------------------
module tb_braced_hex_id_parser_top;

    localparam int TAIL_ITEMS   = 80;
    localparam int TARGET_ITEMS = 750;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [7:0] ch;
        bit         drain_first;
    } pending_char_t;

    logic clk = 1'b0;
    logic rst_n;

    bhid_stream_if #(.payload_t(bhid_pkg::char_word_t)) char_if ();
    bhid_stream_if #(.payload_t(bhid_pkg::id_word_t))   id_if ();

    braced_hex_id_parser_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_if.sink),
        .id_out  (id_if.source)
    );

    always #6 clk = ~clk;

    pending_char_t      char_queue[$];
    bhid_pkg::id_word_t id_expect[$];
    int                 mismatch_count = 0;

    // Parser model state.
    logic [4:0]  parse_pos  = '0;
    logic [31:0] first_acc  = '0;
    logic [31:0] second_acc = '0;
    logic        parse_bad  = 1'b0;

    // Advance the parser model by one accepted character.
    task automatic predict_char(input logic [7:0] c);
        bhid_pkg::id_word_t res;
        logic               is_hex;
        logic [3:0]         nib;
        is_hex = 1'b0;
        nib    = '0;
        if (c >= bhid_pkg::CHAR_DIG_0 && c <= bhid_pkg::CHAR_DIG_9)
        begin
            is_hex = 1'b1;
            nib    = 4'(c - bhid_pkg::CHAR_DIG_0);
        end
        else if (c >= bhid_pkg::CHAR_LC_A && c <= bhid_pkg::CHAR_LC_F)
        begin
            is_hex = 1'b1;
            nib    = 4'(c - bhid_pkg::CHAR_LC_A) + 4'd10;
        end
        else if (c >= bhid_pkg::CHAR_UC_A && c <= bhid_pkg::CHAR_UC_F)
        begin
            is_hex = 1'b1;
            nib    = 4'(c - bhid_pkg::CHAR_UC_A) + 4'd10;
        end

        if (c == bhid_pkg::CHAR_NUL)
        begin
            res.ok          = !parse_bad && parse_pos == bhid_pkg::FULL_LENGTH;
            res.first_word  = res.ok ? first_acc : '0;
            res.second_word = res.ok ? second_acc : '0;
            id_expect.push_back(res);
            parse_pos  = '0;
            first_acc  = '0;
            second_acc = '0;
            parse_bad  = 1'b0;
        end
        else if (parse_pos >= bhid_pkg::FULL_LENGTH)
        begin
            // Anything past the closing brace spoils the string.
            parse_bad = 1'b1;
            parse_pos = bhid_pkg::FULL_LENGTH;
        end
        else
        begin
            if (parse_pos == bhid_pkg::POS_LBRACE)
            begin
                if (c != bhid_pkg::CHAR_LBRACE) parse_bad = 1'b1;
            end
            else if (parse_pos == bhid_pkg::POS_DASH)
            begin
                if (c != bhid_pkg::CHAR_DASH) parse_bad = 1'b1;
            end
            else if (parse_pos == bhid_pkg::POS_RBRACE)
            begin
                if (c != bhid_pkg::CHAR_RBRACE) parse_bad = 1'b1;
            end
            else if (!is_hex)
                parse_bad = 1'b1;
            else if (parse_pos <= bhid_pkg::POS_LAST_HI)
                first_acc = {first_acc[27:0], nib};
            else
                second_acc = {second_acc[27:0], nib};
            parse_pos = parse_pos + 5'd1;
        end
    endtask

    // Chance in percent that an idle burst starts; redrawn now and then so
    // that busy and quiet stretches alternate.
    function automatic int pick_gap_pct();
        unique case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) return bhid_pkg::CHAR_DIG_0 + 8'(nib);
        return (upper ? bhid_pkg::CHAR_UC_A : bhid_pkg::CHAR_LC_A) + 8'(nib - 4'd10);
    endfunction

    task automatic push_char(input logic [7:0] c, input bit drain = 1'b0);
        pending_char_t p;
        p.ch          = c;
        p.drain_first = drain;
        char_queue.push_back(p);
    endtask

    // Build the 19 characters of a well-formed identifier.
    // Case mode: 0 lower, 1 upper, 2 mixed at random.
    task automatic build_id(input logic [31:0] hi, input logic [31:0] lo,
                            input int case_mode, output logic [7:0] s[19]);
        bit upper;
        s[0]  = bhid_pkg::CHAR_LBRACE;
        s[9]  = bhid_pkg::CHAR_DASH;
        s[18] = bhid_pkg::CHAR_RBRACE;
        for (int i = 0; i < 8; i++)
        begin
            upper = (case_mode == 2) ? bit'($urandom_range(0, 1)) : bit'(case_mode);
            s[1 + i] = hex_char(hi[31 - 4*i -: 4], upper);
            upper = (case_mode == 2) ? bit'($urandom_range(0, 1)) : bit'(case_mode);
            s[10 + i] = hex_char(lo[31 - 4*i -: 4], upper);
        end
    endtask

    // Push the first n characters of s, then the zero terminator.
    task automatic push_string(input logic [7:0] s[19], input int n, input bit drain = 1'b0);
        for (int i = 0; i < n; i++)
            push_char(s[i], drain && i == 0);
        push_char(bhid_pkg::CHAR_NUL, drain && n == 0);
    endtask

    // Random string: mostly well formed, some damaged, some pure noise.
    task automatic push_random_string();
        logic [7:0] s[19];
        int         kind;
        int         extra;
        bit         drain;
        drain = ($urandom_range(0, 29) == 0);
        kind  = $urandom_range(0, 9);
        build_id($urandom, $urandom, $urandom_range(0, 2), s);
        case (kind)
            6:
            begin
                s[$urandom_range(0, 18)] = 8'($urandom_range(1, 255));
                push_string(s, 19, drain);
            end
            7: push_string(s, $urandom_range(0, 18), drain);
            8:
            begin
                extra = $urandom_range(1, 4);
                for (int i = 0; i < 19; i++)
                    push_char(s[i], drain && i == 0);
                repeat (extra) push_char(8'($urandom_range(1, 255)));
                push_char(bhid_pkg::CHAR_NUL);
            end
            9:
            begin
                extra = $urandom_range(0, 24);
                push_char(extra == 0 ? bhid_pkg::CHAR_NUL : 8'($urandom_range(1, 255)), drain);
                for (int i = 1; i < extra; i++)
                    push_char(8'($urandom_range(1, 255)));
                if (extra != 0) push_char(bhid_pkg::CHAR_NUL);
            end
            default: push_string(s, 19, drain);
        endcase
    endtask

    // Driver: offers queued characters, predicts on each accepted word.
    int gap_left  = 0;
    int gap_pct   = 15;
    int gap_cycle = 0;
    pending_char_t next_char;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_if.valid   <= 1'b0;
            char_if.payload <= '0;
            gap_left = 0;
        end
        else
        begin
            if (char_if.valid && char_if.ready)
                predict_char(char_if.payload.char_byte);

            gap_cycle++;
            if (gap_cycle % 50 == 0) gap_pct = pick_gap_pct();

            // A word on offer stays put until it is taken.
            if (!char_if.valid || char_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    char_if.valid <= 1'b0;
                end
                else if (char_queue.size() == 0)
                    char_if.valid <= 1'b0;
                else if (char_queue[0].drain_first && id_expect.size() != 0)
                    char_if.valid <= 1'b0;
                else if (char_queue.size() > TAIL_ITEMS && $urandom_range(0, 99) < gap_pct)
                begin
                    gap_left = $urandom_range(0, 5);
                    char_if.valid <= 1'b0;
                end
                else
                begin
                    next_char = char_queue.pop_front();
                    char_if.payload <= next_char.ch;
                    char_if.valid   <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks each returned id word and stalls ready at random.
    int                 stall_left  = 0;
    int                 stall_pct   = 15;
    int                 stall_cycle = 0;
    bhid_pkg::id_word_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (id_if.valid && id_if.ready)
            begin
                if (id_expect.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected id word first=%h second=%h ok=%b", $realtime,
                                 id_if.payload.first_word, id_if.payload.second_word,
                                 id_if.payload.ok);
                end
                else
                begin
                    want = id_expect.pop_front();
                    if (id_if.payload.first_word !== want.first_word ||
                        id_if.payload.second_word !== want.second_word ||
                        id_if.payload.ok !== want.ok)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: id mismatch expected %h/%h/%b got %h/%h/%b",
                                     $realtime, want.first_word, want.second_word, want.ok,
                                     id_if.payload.first_word, id_if.payload.second_word,
                                     id_if.payload.ok);
                    end
                end
            end

            stall_cycle++;
            if (stall_cycle % 50 == 25) stall_pct = pick_gap_pct();

            if (stall_left > 0)
            begin
                stall_left--;
                id_if.ready <= 1'b0;
            end
            else if (char_queue.size() > TAIL_ITEMS && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 5);
                id_if.ready <= 1'b0;
            end
            else
                id_if.ready <= 1'b1;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [7:0] s[19];
        rst_n           = 1'b0;
        char_if.valid   = 1'b0;
        char_if.payload = '0;
        id_if.ready     = 1'b0;

        // Empty string, then the all-zero and all-ones identifiers.
        push_char(bhid_pkg::CHAR_NUL);
        build_id(32'h0, 32'h0, 0, s);
        push_string(s, 19, 1'b1);
        build_id(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, s);
        push_string(s, 19);
        build_id(32'hABCD_EF01, 32'h2345_6789, 0, s);
        push_string(s, 19);
        // Early terminator in the first word.
        push_string(s, 5);
        // Late terminator: one extra high-bit character after the brace.
        for (int i = 0; i < 19; i++) push_char(s[i]);
        push_char(8'hFF);
        push_char(bhid_pkg::CHAR_NUL);
        // Wrong dash, then a non-hex digit.
        build_id(32'h89AB_CDEF, 32'h0123_4567, 2, s);
        s[9] = 8'h80;
        push_string(s, 19);
        s[9]  = bhid_pkg::CHAR_DASH;
        s[12] = 8'h47;
        push_string(s, 19);

        // Random strings; the first one waits for the parser to drain.
        build_id($urandom, $urandom, 2, s);
        push_string(s, 19, 1'b1);
        while (char_queue.size() < TARGET_ITEMS)
            push_random_string();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() != 0 || char_if.valid || id_expect.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && id_expect.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hard stop if the run hangs.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
